// File: design/trainer_ride_file_stream_validator_unit_macros.svh
// Assertion macros for the ride file stream validator.
// Included by the top level; no other dependencies.
`ifndef TRAINER_RIDE_FILE_STREAM_VALIDATOR_UNIT_MACROS_SVH
`define TRAINER_RIDE_FILE_STREAM_VALIDATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define TRFV_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define TRFV_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define TRFV_ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define TRFV_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif
`endif

// File: design/trfv_pkg.sv
// Shared types and constants for the ride file stream validator.
// No dependencies.
package trfv_pkg;

    typedef enum logic [1:0] {
        PH_FILE,
        PH_BLOCK,
        PH_PAYLOAD,
        PH_WAIT
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_HDR_SHORT  = 4'd1,
        ST_BAD_FP     = 4'd2,
        ST_BAD_VER    = 4'd3,
        ST_BLK_SHORT  = 4'd4,
        ST_NEG_SIZE   = 4'd5,
        ST_PAY_SHORT  = 4'd6,
        ST_INFO_SHORT = 4'd7,
        ST_BAD_REC    = 4'd8
    } status_t;

    localparam logic [15:0] FILE_FP          = 16'd3000;
    localparam logic [15:0] VERSION_A        = 16'd100;
    localparam logic [15:0] VERSION_B        = 16'd110;
    localparam logic [31:0] INFO_BLOCK       = 32'd3010;
    localparam logic [31:0] DATA_BLOCK       = 32'd3020;
    localparam logic [31:0] INFO_MIN_PAYLOAD = 32'd20;
    localparam logic [31:0] RECORD_SIZE_A    = 32'd10;
    localparam logic [31:0] RECORD_SIZE_B    = 32'd18;
    localparam logic [3:0]  FILE_HDR_LAST    = 4'd7;
    localparam logic [3:0]  BLK_SIZE_FIRST   = 4'd8;
    localparam logic [3:0]  BLK_HDR_LAST     = 4'd11;
    localparam logic [61:0] PAYLOAD_ONE      = 62'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [15:0] version;
    } verdict_t;

endpackage

// File: design/trainer_ride_file_stream_validator_unit.sv
// Top level of the ride file stream validator.
// Uses trfv_pkg, trfv_in_stage, trfv_parse, trfv_out_stage and the macros header.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------
//  item     | item_valid / item_ready    | data_byte, end_of_stream
//  result   | result_valid / result_ready| status, file_version
//
// One byte per cycle sustained while no result stalls; a verdict passes the input register, then the result register.
// The block header multiply (31 x 31 bits) sits in the parse stage once per block.
// Reset clears the parser to the start of a file and empties both registers.
// A stalled result holds only bytes that would produce a verdict; others pass.
`include "trainer_ride_file_stream_validator_unit_macros.svh"
module trainer_ride_file_stream_validator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_stream,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [3:0]         status,
    output logic signed [15:0] file_version
);

    logic               take;
    logic               held_valid;
    trfv_pkg::item_t    held;
    logic               out_free;
    trfv_pkg::verdict_t verdict;

    trfv_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .take          (take),
        .held_valid    (held_valid),
        .held          (held)
    );

    trfv_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held       (held),
        .out_free   (out_free),
        .take       (take),
        .verdict    (verdict)
    );

    trfv_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && verdict.valid),
        .verdict      (verdict),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .file_version (file_version)
    );

    `TRFV_ASSERT_IMPLY(a_hdr_err_version, clk, rst_n,
        result_valid && (status == 4'(trfv_pkg::ST_HDR_SHORT)
            || status == 4'(trfv_pkg::ST_BAD_FP) || status == 4'(trfv_pkg::ST_BAD_VER)),
        file_version == 16'sd0)
    `TRFV_ASSERT_IMPLY(a_ok_version, clk, rst_n,
        result_valid && (status == 4'(trfv_pkg::ST_OK)),
        (file_version == 16'sd100) || (file_version == 16'sd110))
    `TRFV_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !item_ready, held_valid && result_valid)
    `TRFV_ASSERT_NEXT(a_verdict_lands, clk, rst_n, take && verdict.valid, result_valid)

endmodule

// File: design/trfv_in_stage.sv
// Input register for the byte stream transfer.
// Uses trfv_pkg.
module trfv_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  logic [7:0]      data_byte,
    input  logic            end_of_stream,
    input  logic            take,
    output logic            held_valid,
    output trfv_pkg::item_t held
);

    logic            vld_reg;
    logic            vld_next;
    trfv_pkg::item_t item_reg;

    assign item_ready = !vld_reg || take;
    assign held_valid = vld_reg;
    assign held       = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (item_valid && item_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.data <= data_byte;
            item_reg.last <= end_of_stream;
        end
    end

endmodule

// File: design/trfv_parse.sv
// File and block header parser, payload skip counter and verdict logic.
// Uses trfv_pkg.
module trfv_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               held_valid,
    input  trfv_pkg::item_t    held,
    input  logic               out_free,
    output logic               take,
    output trfv_pkg::verdict_t verdict
);

    trfv_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]        pos_reg, pos_next;
    logic [63:0]       hdr_reg, hdr_next;
    logic [23:0]       size_reg, size_next;
    logic [15:0]       version_reg, version_next;
    logic [61:0]       remain_reg, remain_next;
    trfv_pkg::status_t pend_reg, pend_next;

    logic              emit;
    trfv_pkg::status_t st;
    logic [15:0]       fp16;
    logic [15:0]       ver16;
    logic [31:0]       fp32;
    logic [31:0]       cnt;
    logic [31:0]       sz;
    logic [31:0]       rec;
    logic              zero_pay;
    logic [9:0]        small_prod;
    logic              small_pay;
    trfv_pkg::status_t pend_new;

    assign fp16       = hdr_reg[15:0];
    assign ver16      = hdr_reg[31:16];
    assign fp32       = hdr_reg[31:0];
    assign cnt        = hdr_reg[63:32];
    assign sz         = {held.data, size_reg};
    assign rec        = (version_reg == trfv_pkg::VERSION_B) ? trfv_pkg::RECORD_SIZE_B
                                                             : trfv_pkg::RECORD_SIZE_A;
    assign zero_pay   = (cnt == 32'd0) || (sz == 32'd0);
    assign small_prod = {5'd0, cnt[4:0]} * {5'd0, sz[4:0]};
    assign small_pay  = zero_pay || ((cnt < trfv_pkg::INFO_MIN_PAYLOAD)
                        && (sz < trfv_pkg::INFO_MIN_PAYLOAD)
                        && ({22'd0, small_prod} < trfv_pkg::INFO_MIN_PAYLOAD));

    always_comb
    begin
        if ((fp32 == trfv_pkg::INFO_BLOCK) && small_pay)
        begin
            pend_new = trfv_pkg::ST_INFO_SHORT;
        end
        else if ((fp32 == trfv_pkg::DATA_BLOCK) && (cnt != 32'd0) && (sz < rec))
        begin
            pend_new = trfv_pkg::ST_BAD_REC;
        end
        else
        begin
            pend_new = trfv_pkg::ST_OK;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        size_next    = size_reg;
        version_next = version_reg;
        remain_next  = remain_reg;
        pend_next    = pend_reg;
        emit         = 1'b0;
        st           = trfv_pkg::ST_OK;

        unique case (phase_reg)
            trfv_pkg::PH_FILE:
            begin
                hdr_next[{pos_reg[2:0], 3'b000} +: 8] = held.data;
                pos_next = pos_reg + 4'd1;
                if (pos_reg == trfv_pkg::FILE_HDR_LAST)
                begin
                    pos_next = 4'd0;
                    hdr_next = 64'd0;
                    if (fp16 != trfv_pkg::FILE_FP)
                    begin
                        emit = 1'b1;
                        st   = trfv_pkg::ST_BAD_FP;
                    end
                    else if ((ver16 != trfv_pkg::VERSION_A) && (ver16 != trfv_pkg::VERSION_B))
                    begin
                        emit = 1'b1;
                        st   = trfv_pkg::ST_BAD_VER;
                    end
                    else
                    begin
                        version_next = ver16;
                        phase_next   = trfv_pkg::PH_BLOCK;
                    end
                end
            end
            trfv_pkg::PH_BLOCK:
            begin
                if (pos_reg < trfv_pkg::BLK_SIZE_FIRST)
                begin
                    hdr_next[{pos_reg[2:0], 3'b000} +: 8] = held.data;
                end
                else if (pos_reg < trfv_pkg::BLK_HDR_LAST)
                begin
                    size_next[{pos_reg[1:0], 3'b000} +: 8] = held.data;
                end
                pos_next = pos_reg + 4'd1;
                if (pos_reg == trfv_pkg::BLK_HDR_LAST)
                begin
                    pos_next  = 4'd0;
                    hdr_next  = 64'd0;
                    size_next = 24'd0;
                    if (cnt[31] || sz[31])
                    begin
                        emit = 1'b1;
                        st   = trfv_pkg::ST_NEG_SIZE;
                    end
                    else
                    begin
                        pend_next   = pend_new;
                        remain_next = {31'd0, cnt[30:0]} * {31'd0, sz[30:0]};
                        if (zero_pay)
                        begin
                            if (pend_new != trfv_pkg::ST_OK)
                            begin
                                emit = 1'b1;
                                st   = pend_new;
                            end
                        end
                        else
                        begin
                            phase_next = trfv_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            trfv_pkg::PH_PAYLOAD:
            begin
                remain_next = remain_reg - trfv_pkg::PAYLOAD_ONE;
                if (remain_reg == trfv_pkg::PAYLOAD_ONE)
                begin
                    if (pend_reg != trfv_pkg::ST_OK)
                    begin
                        emit = 1'b1;
                        st   = pend_reg;
                    end
                    else
                    begin
                        phase_next = trfv_pkg::PH_BLOCK;
                    end
                end
            end
            trfv_pkg::PH_WAIT:
            begin
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            phase_next = trfv_pkg::PH_WAIT;
        end

        if (held.last)
        begin
            if (phase_next != trfv_pkg::PH_WAIT)
            begin
                emit = 1'b1;
                unique case (phase_next)
                    trfv_pkg::PH_FILE:    st = trfv_pkg::ST_HDR_SHORT;
                    trfv_pkg::PH_BLOCK:   st = (pos_next == 4'd0) ? trfv_pkg::ST_OK
                                                                  : trfv_pkg::ST_BLK_SHORT;
                    default:              st = trfv_pkg::ST_PAY_SHORT;
                endcase
            end
            phase_next   = trfv_pkg::PH_FILE;
            pos_next     = 4'd0;
            hdr_next     = 64'd0;
            size_next    = 24'd0;
            version_next = 16'd0;
            remain_next  = 62'd0;
            pend_next    = trfv_pkg::ST_OK;
        end
    end

    assign take            = held_valid && (!emit || out_free);
    assign verdict.valid   = emit;
    assign verdict.status  = st;
    assign verdict.version = (held.last || emit) ? ((phase_reg == trfv_pkg::PH_FILE
                             && pos_reg == trfv_pkg::FILE_HDR_LAST && !emit)
                             ? ver16 : ((phase_reg == trfv_pkg::PH_FILE
                             && pos_reg == trfv_pkg::FILE_HDR_LAST
                             && st == trfv_pkg::ST_OK) ? ver16 : version_reg))
                             : version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= trfv_pkg::PH_FILE;
            pos_reg     <= 4'd0;
            hdr_reg     <= 64'd0;
            size_reg    <= 24'd0;
            version_reg <= 16'd0;
            remain_reg  <= 62'd0;
            pend_reg    <= trfv_pkg::ST_OK;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            hdr_reg     <= hdr_next;
            size_reg    <= size_next;
            version_reg <= version_next;
            remain_reg  <= remain_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// File: design/trfv_out_stage.sv
// Result register for the verdict transfer.
// Uses trfv_pkg.
module trfv_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  trfv_pkg::verdict_t verdict,
    output logic               out_free,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [3:0]         status,
    output logic signed [15:0] file_version
);

    logic        vld_reg;
    logic        vld_next;
    logic [3:0]  status_reg;
    logic [15:0] version_reg;

    assign out_free     = !vld_reg || result_ready;
    assign result_valid = vld_reg;
    assign status       = status_reg;
    assign file_version = signed'(version_reg);

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (vld_reg && result_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= 4'(verdict.status);
            version_reg <= verdict.version;
        end
    end

endmodule
